// ===== hdl/ring_fifo_with_threshold_purge_defines.svh =====
// Assertion macros for the ring FIFO with threshold purge.
`ifndef RING_FIFO_WITH_THRESHOLD_PURGE_DEFINES_SVH
`define RING_FIFO_WITH_THRESHOLD_PURGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ring fifo: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ring fifo: next-cycle check failed");

`endif

// ===== hdl/rftp_pkg.sv =====
// Shared types and request codes for the ring FIFO with threshold purge.
package rftp_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic [3:0]         occ_t;
	typedef logic [1:0]         req_t;

	localparam req_t REQ_PUSH  = 2'd0;
	localparam req_t REQ_POP   = 2'd1;
	localparam req_t REQ_PURGE = 2'd2;

endpackage

// ===== hdl/ring_fifo_with_threshold_purge.sv =====
// Ring FIFO of signed words with in-place threshold purge; top level.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, req_type,            | request
//          | push_value, purge_limit                  |
//  out     | out_valid, out_stall, ok, pop_value,     | result
//          | occupancy                                |
//
// Push, unused codes and a pop on an empty ring finish in the cycle the item is accepted.
// Pop reads its word through the slot memory's one registered read port.
// Purge reads each stored entry once; each entry is then checked by the
// single signed comparator and written back if kept.
// Reset (arst_n low) sets both pointers to DEPTH-1; the slot memory is not
// cleared, and no clearing pass runs. A stalled result holds the output
// register; a new item is accepted only once that register can be freed.
`include "ring_fifo_with_threshold_purge_defines.svh"

module ring_fifo_with_threshold_purge import rftp_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  req_t  req_type,
	input  word_t push_value,
	input  word_t purge_limit,
	output logic  out_valid,
	input  logic  out_stall,
	output logic  ok,
	output word_t pop_value,
	output occ_t  occupancy
);

	localparam int PW = $clog2(DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE      = 2'd0;
	localparam logic [1:0] ST_POP_RD    = 2'd1;
	localparam logic [1:0] ST_PURGE_RD  = 2'd2;
	localparam logic [1:0] ST_PURGE_CMP = 2'd3;

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// entries between h (exclusive) and t (inclusive) around the ring
	function automatic logic [PW:0] ring_count(input logic [PW-1:0] t,
	                                           input logic [PW-1:0] h);
		logic [PW:0] diff;
		if (t >= h) begin
			diff = {1'b0, t} - {1'b0, h};
		end else begin
			diff = {1'b0, t} + (PW+1)'(DEPTH) - {1'b0, h};
		end
		return diff;
	endfunction

	logic [1:0]    state_q, state_d;
	logic [PW-1:0] head_q, head_d;
	logic [PW-1:0] tail_q, tail_d;
	logic [PW-1:0] rd_q, rd_d;       // purge read pointer
	logic [PW-1:0] wr_q, wr_d;       // purge compaction pointer
	word_t         limit_q;
	word_t         rdata_q;

	word_t         mem_q [DEPTH];
	logic          mem_we;
	logic [PW-1:0] mem_waddr;
	word_t         mem_wdata;
	logic          mem_re;
	logic [PW-1:0] mem_raddr;

	logic          out_valid_q;
	logic          ok_q;
	word_t         pop_value_q;
	occ_t          occupancy_q;

	logic          out_free;
	logic          in_accept;
	logic          load;
	logic          ok_d;
	word_t         pop_d;
	logic [PW:0]   occ_full;

	// output register can take a new result this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_free;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		rd_d      = rd_q;
		wr_d      = wr_q;
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = push_value;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		load      = 1'b0;
		ok_d      = 1'b0;
		pop_d     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					unique case (req_type)
						REQ_PUSH: begin
							load = 1'b1;
							if (next_slot(tail_q) != head_q) begin
								tail_d    = next_slot(tail_q);
								mem_we    = 1'b1;
								mem_waddr = next_slot(tail_q);
								ok_d      = 1'b1;
							end
						end
						REQ_POP: begin
							if (head_q != tail_q) begin
								head_d    = next_slot(head_q);
								mem_re    = 1'b1;
								mem_raddr = next_slot(head_q);
								state_d   = ST_POP_RD;
							end else begin
								load = 1'b1;
							end
						end
						REQ_PURGE: begin
							rd_d    = head_q;
							wr_d    = head_q;
							state_d = ST_PURGE_RD;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			ST_POP_RD: begin
				if (out_free) begin
					load    = 1'b1;
					ok_d    = 1'b1;
					pop_d   = rdata_q;
					state_d = ST_IDLE;
				end
			end
			ST_PURGE_RD: begin
				if (rd_q == tail_q) begin
					// walk done: kept entries end at the compaction pointer
					if (out_free) begin
						tail_d  = wr_q;
						load    = 1'b1;
						ok_d    = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					rd_d      = next_slot(rd_q);
					mem_re    = 1'b1;
					mem_raddr = next_slot(rd_q);
					state_d   = ST_PURGE_CMP;
				end
			end
			ST_PURGE_CMP: begin
				if (rdata_q >= limit_q) begin
					wr_d      = next_slot(wr_q);
					mem_we    = 1'b1;
					mem_waddr = next_slot(wr_q);
					mem_wdata = rdata_q;
				end
				state_d = ST_PURGE_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		occ_full = ring_count(tail_d, head_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= PTR_LAST;
			tail_q      <= PTR_LAST;
			rd_q        <= PTR_LAST;
			wr_q        <= PTR_LAST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			rd_q    <= rd_d;
			wr_q    <= wr_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result and threshold payload
	always_ff @(posedge clk) begin
		if (load) begin
			ok_q        <= ok_d;
			pop_value_q <= pop_d;
			occupancy_q <= 4'(occ_full);
		end
		if (in_accept && req_type == REQ_PURGE) begin
			limit_q <= purge_limit;
		end
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign pop_value = pop_value_q;
	assign occupancy = occupancy_q;

	// ring never holds more than DEPTH-1 entries
	`RFTP_ASSERT_NOW(a_occ_bound, clk, arst_n, 1'b1,
		ring_count(tail_q, head_q) <= (PW+1)'(DEPTH - 1))

	// compaction pointer never overtakes the read pointer
	`RFTP_ASSERT_NOW(a_purge_order, clk, arst_n,
		state_q == ST_PURGE_RD || state_q == ST_PURGE_CMP,
		ring_count(wr_q, head_q) <= ring_count(rd_q, head_q))

	// purge leaves the head untouched
	`RFTP_ASSERT_NEXT(a_purge_head, clk, arst_n,
		state_q == ST_PURGE_RD || state_q == ST_PURGE_CMP, $stable(head_q))

	// a push into a full ring is refused
	`RFTP_ASSERT_NEXT(a_push_full, clk, arst_n,
		in_accept && req_type == REQ_PUSH && next_slot(tail_q) == head_q,
		out_valid && !ok && $stable(tail_q))

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the ring FIFO with threshold purge.
module tb import rftp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int   DEPTH      = 16;
	localparam int   RUN_LIMIT  = 400000;  // cycles, several times the slowest clean run
	localparam int   LONG_HOLD  = 160;     // receiver hold-off, in cycles
	localparam int   DRAIN_WAIT = 40;      // wait before the summary, in cycles
	localparam int   PHASE_SIZE = 350;     // random items per idling phase
	localparam req_t REQ_UNUSED = 2'd3;    // code the block ignores

	typedef logic [$clog2(DEPTH)-1:0] slot_t;

	typedef struct {
		req_t  kind;
		word_t value;
		word_t limit;
	} fifo_request_t;

	typedef struct {
		logic  ok;
		word_t pop_value;
		occ_t  occupancy;
	} fifo_response_t;

	// Clock and reset. Reset is held low from time zero.
	logic clk;
	logic arst_n = 1'b0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Block ports. Every input has a known value from the start.
	logic  in_valid    = 1'b0;
	logic  in_stall;
	req_t  req_type    = REQ_PUSH;
	word_t push_value  = '0;
	word_t purge_limit = '0;
	logic  out_valid;
	logic  out_stall   = 1'b0;
	logic  ok;
	word_t pop_value;
	occ_t  occupancy;

	ring_fifo_with_threshold_purge #(
		.DEPTH(DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.push_value  (push_value),
		.purge_limit (purge_limit),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.pop_value   (pop_value),
		.occupancy   (occupancy)
	);

	// Items waiting to be offered, and responses waiting to come out.
	fifo_request_t  pending_requests[$];
	fifo_response_t expected_responses[$];

	// Idling knobs, changed only between phases while everything is idle.
	int sender_gap_max   = 0;
	int receiver_gap_max = 0;

	int mismatches   = 0;
	int results_seen = 0;
	int cycle_count  = 0;

	// Coverage tallies for the summary.
	int n_push_ok, n_push_full, n_pop_ok, n_pop_empty, n_purge, n_unused;
	int peak_occupancy;

	// ------------------------------------------------------------------
	// Predictor: a private copy of the ring. head is the slot just before
	// the oldest word, tail holds the newest; equal pointers mean empty,
	// so one slot always stays unused and the ring holds DEPTH-1 words.
	// ------------------------------------------------------------------
	word_t ring_words[DEPTH];
	slot_t ring_head = slot_t'(DEPTH - 1);
	slot_t ring_tail = slot_t'(DEPTH - 1);

	function automatic slot_t slot_after(slot_t p);
		return (p >= slot_t'(DEPTH - 1)) ? slot_t'(0) : slot_t'(p + 1'b1);
	endfunction

	function automatic fifo_response_t next_response(req_t kind, word_t value, word_t limit);
		fifo_response_t resp;
		slot_t          rd;
		slot_t          wr;
		resp.ok        = 1'b0;
		resp.pop_value = '0;
		case (kind)
			REQ_PUSH: begin
				// refused when advancing tail would land on head
				if (slot_after(ring_tail) != ring_head) begin
					ring_tail             = slot_after(ring_tail);
					ring_words[ring_tail] = value;
					resp.ok               = 1'b1;
				end
			end
			REQ_POP: begin
				if (ring_head != ring_tail) begin
					ring_head      = slot_after(ring_head);
					resp.pop_value = ring_words[ring_head];
					resp.ok        = 1'b1;
				end
			end
			REQ_PURGE: begin
				// compact kept words toward head, order preserved;
				// the compare is signed and keeps words equal to the limit
				rd = ring_head;
				wr = ring_head;
				while (rd != ring_tail) begin
					rd = slot_after(rd);
					if (ring_words[rd] >= limit) begin
						wr             = slot_after(wr);
						ring_words[wr] = ring_words[rd];
					end
				end
				ring_tail = wr;
				resp.ok   = 1'b1;
			end
			default: ;  // unused code: nothing changes, ok stays low
		endcase
		resp.occupancy = occ_t'((int'(ring_tail) + DEPTH - int'(ring_head)) % DEPTH);
		return resp;
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers pending items, predicts each one as it is accepted,
	// then idles for a drawn number of cycles before the next item.
	// ------------------------------------------------------------------
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : drive
		fifo_request_t  req;
		fifo_response_t resp;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			req_type    <= REQ_PUSH;
			push_value  <= '0;
			purge_limit <= '0;
			gap_left    = 0;
			ring_head   = slot_t'(DEPTH - 1);
			ring_tail   = slot_t'(DEPTH - 1);
		end else begin
			if (in_valid && !in_stall) begin
				resp = next_response(req_type, push_value, purge_limit);
				expected_responses.push_back(resp);
				case (req_type)
					REQ_PUSH:  if (resp.ok) n_push_ok++; else n_push_full++;
					REQ_POP:   if (resp.ok) n_pop_ok++; else n_pop_empty++;
					REQ_PURGE: n_purge++;
					default:   n_unused++;
				endcase
				if (int'(resp.occupancy) > peak_occupancy)
					peak_occupancy = int'(resp.occupancy);
				gap_left = $urandom_range(0, sender_gap_max);
			end
			// a stalled item holds its payload; only a free slot moves on
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					req = pending_requests.pop_front();
					in_valid    <= 1'b1;
					req_type    <= req.kind;
					push_value  <= req.value;
					purge_limit <= req.limit;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each accepted result against the oldest prediction
	// and draws its own stall per item. Twice in the run it takes the long
	// hold-off LONG_HOLD, so the block backs up and stalls its input.
	// ------------------------------------------------------------------
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin : observe
		fifo_response_t want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_responses.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected: ok %0b pop_value %0d occupancy %0d",
						$time, ok, pop_value, occupancy);
				end else begin
					want = expected_responses.pop_front();
					if (ok !== want.ok) begin
						mismatches++;
						$display("%0t: ok expected %0b, got %0b", $time, want.ok, ok);
					end
					if (pop_value !== want.pop_value) begin
						mismatches++;
						$display("%0t: pop_value expected %0d, got %0d",
							$time, want.pop_value, pop_value);
					end
					if (occupancy !== want.occupancy) begin
						mismatches++;
						$display("%0t: occupancy expected %0d, got %0d",
							$time, want.occupancy, occupancy);
					end
				end
				results_seen++;
				if (results_seen % 700 == 300)
					stall_left = LONG_HOLD;
				else
					stall_left = $urandom_range(0, receiver_gap_max);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_responses.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_request(req_t kind, word_t value, word_t limit);
		fifo_request_t req;
		req.kind  = kind;
		req.value = value;
		req.limit = limit;
		pending_requests.push_back(req);
	endtask

	// Words spread over the whole range, with weight near zero and the
	// extremes so that purges split the stored words in varied ways.
	function automatic word_t random_word();
		case ($urandom_range(0, 5))
			0:       return word_t'($urandom_range(0, 40)) - 20;
			1:       return word_t'(32'h8000_0000 + $urandom_range(0, 15));
			2:       return word_t'(32'h7fff_ffff - $urandom_range(0, 15));
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic wait_idle();
		while (pending_requests.size() != 0 || in_valid || expected_responses.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int push_pct;
		int pop_pct;
		int burst_left;
		int pick;
		req_t kind;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: refusals and purge on an empty ring, the unused code,
		// extremes of the word range, keep-all and signed purges, a full ring.
		queue_request(REQ_POP, '0, '0);
		queue_request(REQ_PURGE, '0, '0);
		queue_request(REQ_UNUSED, 32'h5a5a_5a5a, 32'ha5a5_a5a5);
		queue_request(REQ_PUSH, 32'h8000_0000, '0);
		queue_request(REQ_PUSH, 32'h7fff_ffff, '0);
		queue_request(REQ_PUSH, 32'hffff_ffff, '0);
		queue_request(REQ_PUSH, 32'h0000_0000, '0);
		queue_request(REQ_PUSH, 32'h0000_0001, '0);
		queue_request(REQ_PURGE, '0, 32'h8000_0000);   // lowest limit keeps all
		queue_request(REQ_PURGE, '0, 32'h0000_0000);   // drops the negatives
		queue_request(REQ_POP, '0, '0);
		repeat (12) queue_request(REQ_PUSH, word_t'($urandom), '0);
		queue_request(REQ_PUSH, 32'h7fff_ffff, '0);    // ring now full
		queue_request(REQ_PUSH, 32'h1234_5678, '0);    // refused
		queue_request(REQ_PURGE, '0, 32'h7fff_ffff);   // keeps only words equal to it
		wait_idle();

		// Random phases: no idling, both sides idling, then each side alone.
		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			sender_gap_max   = (phase == 1 || phase == 3) ? 8 : 0;
			receiver_gap_max = (phase == 1 || phase == 2) ? 8 : 0;
			burst_left = 0;
			push_pct   = 45;
			pop_pct    = 45;
			for (int n = 0; n < PHASE_SIZE; n++) begin
				// bursts that fill, drain or mix, so the ring visits full,
				// empty and wrapped states with purges in between
				if (burst_left == 0) begin
					burst_left = $urandom_range(4, 20);
					case ($urandom_range(0, 2))
						0:       begin push_pct = 75; pop_pct = 15; end
						1:       begin push_pct = 15; pop_pct = 75; end
						default: begin push_pct = 45; pop_pct = 45; end
					endcase
				end
				burst_left--;
				pick = $urandom_range(0, 99);
				if (pick < push_pct)
					kind = REQ_PUSH;
				else if (pick < push_pct + pop_pct)
					kind = REQ_POP;
				else if (pick < 98)
					kind = REQ_PURGE;
				else
					kind = REQ_UNUSED;
				queue_request(kind, random_word(), random_word());
			end
			wait_idle();
		end

		repeat (DRAIN_WAIT) @(negedge clk);

		$display("covered %0d pushes (%0d refused when full), %0d pops (%0d refused when empty)",
			n_push_ok + n_push_full, n_push_full, n_pop_ok + n_pop_empty, n_pop_empty);
		$display("and %0d purges, %0d unused codes; peak occupancy %0d, %0d results checked",
			n_purge, n_unused, peak_occupancy, results_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rftp_pkg.sv
hdl/ring_fifo_with_threshold_purge.sv
dv/tb.sv
